// ===== hw/rtl/ipq_pkg.sv =====
// Shared constants and types of the interlaced pair quantizer.
// Used by ipq_lane and interlaced_pair_quantizer; depends on nothing.
package ipq_pkg;

	localparam int VALUE_W = 16;
	localparam int SCALE_W = 19;
	localparam int STEP_W  = 4;
	localparam int JOINT_W = 5;
	localparam int CODE_W  = 8;

	localparam logic [SCALE_W-1:0] MID_SCALE = 19'd245760;
	localparam logic [SCALE_W:0]   ONE_STEP  = 20'd32768;
	localparam logic [14:0]        WIN_LO    = 15'd8192;
	localparam logic [14:0]        WIN_HI    = 15'd24576;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN = -16'sd16384;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sd16384;

	// Register index of the interlace enable bit.
	localparam logic REG_INTERLACE = 1'b0;

	typedef logic [SCALE_W-1:0] scale_t;
	typedef logic [STEP_W-1:0]  step_t;

endpackage

// ===== hw/rtl/interlaced_pair_quantizer.sv =====
// Top level of the interlaced pair quantizer: pipeline, history store, register port.
// Depends on ipq_pkg and ipq_lane.
//
// Usage:
// An item (joint_index, left_value, right_value) is transferred on the input
// channel at a clock edge where in_valid is high and in_stall is low. Each
// item produces exactly one result (packed_code, left_step, right_step) on the
// output channel, transferred where out_valid is high and out_stall is low.
// The item is first captured in an input register; when the output register
// is empty or drained, it moves through the scaling, interlacing and
// rounding logic into the output register, from which its result is
// offered. One item is taken every cycle while the output does not stall;
// the per-joint history is read and updated in the same cycle, so
// consecutive items on one joint see each other's updates.
// When the receiver stalls, the output register holds its result and the
// input register fills; in_stall then rises until the output drains.
// Reset empties both registers, clears interlace_enable and sets every
// history entry to mid scale at once. The register interlace_enable lies at
// byte address 0 and is written with an ordinary setup and access cycle.
module interlaced_pair_quantizer #(
	parameter int JOINTS = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ipq_pkg::JOINT_W-1:0]        joint_index,
	input  logic signed [ipq_pkg::VALUE_W-1:0] left_value,
	input  logic signed [ipq_pkg::VALUE_W-1:0] right_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ipq_pkg::CODE_W-1:0]         packed_code,
	output ipq_pkg::step_t                     left_step,
	output ipq_pkg::step_t                     right_step,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import ipq_pkg::*;

	localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// Input register stage.
	logic                      valid_s1;
	logic [JOINT_W-1:0]        joint_s1;
	logic signed [VALUE_W-1:0] left_s1;
	logic signed [VALUE_W-1:0] right_s1;

	// Output register stage.
	logic       valid_s2;
	step_t      left_step_s2;
	step_t      right_step_s2;

	logic       interlace_q;
	scale_t     left_hist_q  [JOINTS];
	scale_t     right_hist_q [JOINTS];

	logic       advance;
	logic       fire;
	logic       joint_ok;
	logic [6:0] joint_ext;
	logic [IDX_W-1:0] joint_idx;
	scale_t     left_old;
	scale_t     right_old;
	scale_t     left_new;
	scale_t     right_new;
	step_t      left_q;
	step_t      right_q;

	// The output register takes a new result whenever it is empty or drained.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign joint_ext = {2'b00, joint_s1};
	assign joint_idx = joint_ext[IDX_W-1:0];
	assign joint_ok  = joint_ext < 7'(JOINTS);

	// History is read for every item and used only when interlacing; a joint outside the store uses mid scale.
	always_comb begin
		if (joint_ok) begin
			left_old  = left_hist_q[joint_idx];
			right_old = right_hist_q[joint_idx];
		end else begin
			left_old  = MID_SCALE;
			right_old = MID_SCALE;
		end
	end

	ipq_lane u_left (
		.value    (left_s1),
		.old      (left_old),
		.enable   (interlace_q),
		.hist_new (left_new),
		.step     (left_q)
	);

	ipq_lane u_right (
		.value    (right_s1),
		.old      (right_old),
		.enable   (interlace_q),
		.hist_new (right_new),
		.step     (right_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			joint_s1 <= joint_index;
			left_s1  <= left_value;
			right_s1 <= right_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_step_s2  <= left_q;
			right_step_s2 <= right_q;
		end
	end

	// The history entry is updated as its item leaves the input register, when interlacing and the joint is in the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++) begin
				left_hist_q[i]  <= MID_SCALE;
				right_hist_q[i] <= MID_SCALE;
			end
		end else if (fire && interlace_q && joint_ok) begin
			left_hist_q[joint_idx]  <= left_new;
			right_hist_q[joint_idx] <= right_new;
		end
	end

	// Register port: one register, written in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interlace_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INTERLACE)) begin
			interlace_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INTERLACE) ? {31'd0, interlace_q} : 32'd0;

	assign out_valid   = valid_s2;
	assign left_step   = left_step_s2;
	assign right_step  = right_step_s2;
	assign packed_code = {left_step_s2, right_step_s2};

endmodule

// ===== hw/rtl/ipq_lane.sv =====
// One side of the quantizer: scaling, interlacing against history, rounding.
// Depends on ipq_pkg.
module ipq_lane (
	input  logic signed [ipq_pkg::VALUE_W-1:0] value,
	input  ipq_pkg::scale_t                    old,
	input  logic                               enable,
	output ipq_pkg::scale_t                    hist_new,
	output ipq_pkg::step_t                     step
);
	import ipq_pkg::*;

	logic signed [VALUE_W-1:0] sat;
	logic [VALUE_W-1:0]        offset;
	logic [SCALE_W:0]          scaled;
	logic                      in_window;
	logic [SCALE_W:0]          low;
	logic [SCALE_W:0]          up;
	logic [SCALE_W:0]          old_ext;
	logic [SCALE_W:0]          dlow;
	logic [SCALE_W:0]          dup;
	logic [SCALE_W:0]          dnear;
	logic [SCALE_W:0]          dfar;
	logic [SCALE_W:0]          chosen;
	logic [SCALE_W+1:0]        rounded;

	always_comb begin
		if (value < VALUE_MIN) begin
			sat = VALUE_MIN;
		end else if (value > VALUE_MAX) begin
			sat = VALUE_MAX;
		end else begin
			sat = value;
		end
		offset = VALUE_W'(sat - VALUE_MIN);
		// Times fifteen as a shift and a subtract.
		scaled = ({offset, 4'b0000} - {4'b0000, offset});

		in_window = (scaled[14:0] >= WIN_LO) && (scaled[14:0] <= WIN_HI);
		low     = {scaled[SCALE_W:15], 15'd0};
		up      = low + ONE_STEP;
		old_ext = {1'b0, old};
		dlow    = (low > old_ext) ? (low - old_ext) : (old_ext - low);
		dup     = (up > old_ext) ? (up - old_ext) : (old_ext - up);

		// A far lower step turns the choice around toward the nearer one.
		if (dlow > ONE_STEP) begin
			dnear = dup;
			dfar  = dlow;
		end else begin
			dnear = dlow;
			dfar  = dup;
		end

		if (enable && in_window) begin
			chosen = (dnear < dfar) ? up : low;
		end else begin
			chosen = scaled;
		end

		hist_new = chosen[SCALE_W-1:0];
		rounded  = {1'b0, chosen} + (SCALE_W+2)'(16384);
		if (rounded[SCALE_W+1:15] > 6'd15) begin
			step = 4'd15;
		end else begin
			step = rounded[18:15];
		end
	end

endmodule
